// ----- hw/rtl/masked_box_blur_macros.svh -----
// assertion macros used by the checker
`ifndef MASKED_BOX_BLUR_MACROS_SVH
`define MASKED_BOX_BLUR_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define MBB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define MBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mbb_pkg.sv -----
`default_nettype none

package mbb_pkg;

  localparam int unsigned DefMaxWidth  = 512;
  localparam int unsigned DefMaxHeight = 512;
  localparam int unsigned DefMaxKernel = 15;

  localparam int unsigned KernelW = 4;
  localparam int unsigned DimW    = 10;
  localparam int unsigned CoordW  = 9;
  localparam int unsigned ChanW   = 8;

  localparam logic [KernelW-1:0] KernelReset = 4'd3;
  localparam logic [DimW-1:0]    WidthReset  = 10'd480;
  localparam logic [DimW-1:0]    HeightReset = 10'd320;

  // fixed-point reciprocal of k*k, indexed by k; zero for even k
  localparam int unsigned RecipShift = 16;
  localparam int unsigned RecipW     = 17;
  localparam logic [RecipW-1:0] AreaRecip [16] = '{
    17'd0,     17'd65536, 17'd0, 17'd7282,
    17'd0,     17'd2622,  17'd0, 17'd1338,
    17'd0,     17'd810,   17'd0, 17'd542,
    17'd0,     17'd388,   17'd0, 17'd292
  };

  typedef enum logic [1:0] {
    CFG_KERNEL_SIZE  = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CENTRE = 5'b00010,
    ST_SWEEP  = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/mbb_ram.sv -----
`default_nettype none

module mbb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/masked_box_blur.sv -----
`default_nettype none

// Masked box blur over a stored BGR frame. A store request (tuser 0) writes one pixel and
// its mask byte into a single-port frame memory and answers zeros; a read request (tuser 1)
// answers the stored pixel, or, when its mask byte is 1, kernel_size is odd and no larger
// than MAX_KERNEL, and the k by k window fits inside the frame in use, the sum over the
// window of each channel's pixels, each divided by k*k (result tuser 1). One request is
// worked on at a time, and a finished result waits in the output register while the next
// request is taken. During a filtered read the window (3 by 3 by default) is fetched one
// pixel per cycle through the single memory port. The frame memory has no reset; reading
// a pixel that was never written gives undefined data. The user must write configuration
// through cfg_we_i only while idle; the block itself does not enforce this.
module masked_box_blur #(
  parameter int unsigned MAX_WIDTH  = mbb_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = mbb_pkg::DefMaxHeight,
  parameter int unsigned MAX_KERNEL = mbb_pkg::DefMaxKernel
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [9:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // row, col, blue_in, green_in, red_in, mask_in, zero padding
  input  wire logic [55:0] s_axis_tdata,
  // opcode
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // blue_out, green_out, red_out
  output logic      [23:0] m_axis_tdata,
  // was_blurred
  output logic             m_axis_tuser
);

  localparam int unsigned Depth  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned MaxDim = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned CmpW   = ($clog2(MaxDim) + 2 > 11) ? $clog2(MaxDim) + 2 : 11;
  localparam logic [AddrW-1:0] RowStep = AddrW'(MAX_WIDTH);
  localparam logic [CmpW-1:0]  MaxRows = CmpW'(MAX_HEIGHT);
  localparam logic [CmpW-1:0]  MaxCols = CmpW'(MAX_WIDTH);
  localparam logic [5:0]       MaxKern = 6'(MAX_KERNEL);
  localparam int unsigned PW = mbb_pkg::RecipW + mbb_pkg::ChanW;

  // configuration
  logic [3:0] kernel_q;
  logic [9:0] fwidth_q, fheight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q  <= mbb_pkg::KernelReset;
      fwidth_q  <= mbb_pkg::WidthReset;
      fheight_q <= mbb_pkg::HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mbb_pkg::CFG_KERNEL_SIZE:  kernel_q  <= cfg_data_i[3:0];
        mbb_pkg::CFG_FRAME_WIDTH:  fwidth_q  <= cfg_data_i;
        mbb_pkg::CFG_FRAME_HEIGHT: fheight_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request fields
  logic       in_op;
  logic [8:0] in_row, in_col;
  logic [7:0] in_blue, in_green, in_red, in_mask;

  assign in_op    = s_axis_tuser;
  assign in_row   = s_axis_tdata[8:0];
  assign in_col   = s_axis_tdata[17:9];
  assign in_blue  = s_axis_tdata[25:18];
  assign in_green = s_axis_tdata[33:26];
  assign in_red   = s_axis_tdata[41:34];
  assign in_mask  = s_axis_tdata[49:42];

  mbb_pkg::state_e state_q, state_d;

  logic             in_acc, in_store, ram_we;
  logic [AddrW-1:0] in_addr, ram_addr;
  logic [31:0]      ram_wdata, ram_rdata;

  assign s_axis_tready = (state_q == mbb_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_store      = (CmpW'(in_row) < MaxRows) && (CmpW'(in_col) < MaxCols);
  assign in_addr       = AddrW'(in_row) * RowStep + AddrW'(in_col);
  assign ram_we        = in_acc && (in_op == mbb_pkg::OP_STORE) && in_store;
  assign ram_wdata     = {in_mask, in_red, in_green, in_blue};

  // request context and window walk
  logic [8:0]       row_q, col_q;
  logic             in_store_q;
  logic [AddrW-1:0] addr_q;
  logic [3:0]       wx_q, wy_q;
  logic             rd_vld_q, prod_vld_q;
  logic [7:0]       qb_q, qg_q, qr_q;
  logic [7:0]       acc_b_q, acc_g_q, acc_r_q;
  logic             blur_q;

  assign ram_addr = (state_q == mbb_pkg::ST_SWEEP) ? addr_q : in_addr;

  mbb_ram #(
    .Width(32),
    .Depth(Depth)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // filter decision on the centre pixel
  logic [2:0]       half;
  logic [CmpW-1:0]  h_ext, row_ext, col_ext, rows, cols;
  logic             fits, do_blur;
  logic [AddrW-1:0] start_addr;
  logic [3:0]       km1;
  logic             last_col, last_pos;

  assign half    = kernel_q[3:1];
  assign h_ext   = CmpW'(half);
  assign row_ext = CmpW'(row_q);
  assign col_ext = CmpW'(col_q);
  assign rows    = (CmpW'(fheight_q) < MaxRows) ? CmpW'(fheight_q) : MaxRows;
  assign cols    = (CmpW'(fwidth_q) < MaxCols) ? CmpW'(fwidth_q) : MaxCols;
  assign fits    = (row_ext >= h_ext) && (col_ext >= h_ext)
                && (row_ext + h_ext < rows) && (col_ext + h_ext < cols);
  assign do_blur = in_store_q && (ram_rdata[31:24] == 8'd1) && kernel_q[0]
                && ({2'b00, kernel_q} <= MaxKern) && fits;
  assign start_addr = AddrW'(row_q - 9'(half)) * RowStep + AddrW'(col_q - 9'(half));

  assign km1      = kernel_q - 4'd1;
  assign last_col = (wx_q == km1);
  assign last_pos = last_col && (wy_q == km1);

  // divide by the window area through its reciprocal
  logic [mbb_pkg::RecipW-1:0] recip;
  logic [PW-1:0]              prod_b, prod_g, prod_r;

  assign recip  = mbb_pkg::AreaRecip[kernel_q];
  assign prod_b = PW'(ram_rdata[7:0]) * PW'(recip);
  assign prod_g = PW'(ram_rdata[15:8]) * PW'(recip);
  assign prod_r = PW'(ram_rdata[23:16]) * PW'(recip);

  logic        out_load;
  logic        m_valid_q, m_valid_d;
  logic [23:0] m_data_q;
  logic        m_user_q;

  assign out_load  = (state_q == mbb_pkg::ST_DONE) && (!m_valid_q || m_axis_tready);
  assign m_valid_d = out_load || (m_valid_q && !m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbb_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_op == mbb_pkg::OP_READ) ? mbb_pkg::ST_CENTRE : mbb_pkg::ST_DONE;
        end
      end
      mbb_pkg::ST_CENTRE: begin
        state_d = do_blur ? mbb_pkg::ST_SWEEP : mbb_pkg::ST_DONE;
      end
      mbb_pkg::ST_SWEEP: begin
        if (last_pos) begin
          state_d = mbb_pkg::ST_DRAIN;
        end
      end
      mbb_pkg::ST_DRAIN: begin
        if (!rd_vld_q && !prod_vld_q) begin
          state_d = mbb_pkg::ST_DONE;
        end
      end
      mbb_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = mbb_pkg::ST_IDLE;
        end
      end
      default: state_d = mbb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mbb_pkg::ST_IDLE;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= (state_q == mbb_pkg::ST_SWEEP);
      prod_vld_q <= rd_vld_q;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      row_q      <= in_row;
      col_q      <= in_col;
      in_store_q <= in_store;
      acc_b_q    <= 8'd0;
      acc_g_q    <= 8'd0;
      acc_r_q    <= 8'd0;
      blur_q     <= 1'b0;
    end
    if (state_q == mbb_pkg::ST_CENTRE) begin
      blur_q <= do_blur;
      addr_q <= start_addr;
      wx_q   <= 4'd0;
      wy_q   <= 4'd0;
      if (!do_blur && in_store_q) begin
        acc_b_q <= ram_rdata[7:0];
        acc_g_q <= ram_rdata[15:8];
        acc_r_q <= ram_rdata[23:16];
      end
    end
    if (state_q == mbb_pkg::ST_SWEEP) begin
      if (last_col) begin
        addr_q <= addr_q + RowStep - AddrW'(km1);
        wx_q   <= 4'd0;
        wy_q   <= wy_q + 4'd1;
      end else begin
        addr_q <= addr_q + AddrW'(1);
        wx_q   <= wx_q + 4'd1;
      end
    end
    if (rd_vld_q) begin
      qb_q <= prod_b[mbb_pkg::RecipShift +: 8];
      qg_q <= prod_g[mbb_pkg::RecipShift +: 8];
      qr_q <= prod_r[mbb_pkg::RecipShift +: 8];
    end
    // the window sum never exceeds 255
    if (prod_vld_q) begin
      acc_b_q <= acc_b_q + qb_q;
      acc_g_q <= acc_g_q + qg_q;
      acc_r_q <= acc_r_q + qr_q;
    end
    if (out_load) begin
      m_data_q <= {acc_r_q, acc_g_q, acc_b_q};
      m_user_q <= blur_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

// ----- hw/rtl/mbb_checker.sv -----
`default_nettype none

`include "masked_box_blur_macros.svh"

module mbb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q, pend_d;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // requests taken but not yet answered
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `MBB_ASSERT_NEXT(a_one_request, in_acc, !s_axis_tready, "request taken while busy")
  `MBB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `MBB_ASSERT_NOW(a_pend_bound, 1'b1, pend_q <= 2'd2, "too many requests in flight")
  `MBB_ASSERT_NOW(a_no_spurious, m_axis_tvalid, pend_q != 2'd0, "result without request")

endmodule

bind masked_box_blur mbb_checker u_mbb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
